// ===== sv/iee_pkg.sv =====
`timescale 1ns / 1ps
// iee_pkg: shared types, character codes and helpers for the infix expression evaluator
// used by the channel interfaces, the controller, the datapath and the top level

package iee_pkg;

  localparam int DATA_W = 32;
  localparam int SYM_W  = 8;
  localparam int CNT_W  = $clog2(DATA_W);

  // ascii codes the parser cares about
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_DIV,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;         // latch the incoming byte, fold in a digit
    logic apply_arith;  // apply add, subtract or multiply
    logic div_start;    // launch the serial divider
    logic div_commit;   // write back the quotient
    logic emit;         // load the result register and clear the state
  } iee_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_close;   // incoming byte closes the current number
    logic last;       // latched byte was the final one
    logic op_is_div;  // pending operator is divide
    logic div_done;   // divider has its quotient
    logic out_free;   // result register can take a new value
  } iee_stat_t;

  function automatic logic is_digit(input logic [SYM_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_white(input logic [SYM_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // operator selected by a closing byte; anything unknown means divide
  function automatic op_t sym_op(input logic [SYM_W-1:0] c);
    op_t op;
    if (c == CH_PLUS) begin
      op = OP_ADD;
    end else if (c == CH_MINUS) begin
      op = OP_SUB;
    end else if (c == CH_STAR) begin
      op = OP_MUL;
    end else begin
      op = OP_DIV;
    end
    return op;
  endfunction

endpackage

// ===== sv/iee_in_if.sv =====
`timescale 1ns / 1ps
// iee_in_if: input byte channel, valid/ready handshake with symbol and end marker
// depends on iee_pkg for field widths

interface iee_in_if;
  import iee_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

// ===== sv/iee_out_if.sv =====
`timescale 1ns / 1ps
// iee_out_if: result channel, valid/ready handshake with value and divide-by-zero flag
// depends on iee_pkg for field widths

interface iee_out_if;
  import iee_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     div_by_zero;

  modport source (output valid, output value, output div_by_zero, input ready);
  modport sink   (input valid, input value, input div_by_zero, output ready);
endinterface

// ===== sv/infix_expression_evaluator_unit.sv =====
`timescale 1ns / 1ps
// infix_expression_evaluator_unit: evaluates an ascii infix expression with + - * /
// depends on iee_pkg, iee_in_if, iee_out_if, iee_ctrl and iee_dpath
//
// Usage:
//   in_ch takes one ascii byte per transaction together with end_of_expr, which
//   marks the final byte. Digits build a number, white space is skipped, any
//   other byte closes the number and selects the next operator (unknown bytes
//   mean divide). * and / bind tighter than + and -; all arithmetic wraps at
//   32 bits and division truncates toward zero.
//   out_ch carries one transaction per expression: the value and a flag that is
//   set if any division saw a zero divisor (that quotient reads as 0).
// Sequencing:
//   digit and white space bytes are taken directly in the idle state. A closing
//   byte then passes through an apply step for add, subtract and multiply; a
//   pending divide instead waits for the 32 single-bit steps of the serial
//   restoring divider. The final byte adds a step to load the result register,
//   from which the result is presented on out_ch.
// Reset and stalls:
//   reset clears the expression state and drops out_ch.valid. A held result
//   does not block the input; the output side stalls only when a new result
//   is ready while the previous one has not yet been taken.

module infix_expression_evaluator_unit (
  input  logic      clk,
  input  logic      rst_n,
  iee_in_if.sink    in_ch,
  iee_out_if.source out_ch
);
  import iee_pkg::*;

  iee_cmd_t          cmd;
  iee_stat_t         st;
  logic              ctl_in_ready;
  logic              dp_out_valid;
  logic [DATA_W-1:0] dp_out_value;
  logic              dp_out_dz;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  iee_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_symbol       (in_ch.symbol),
    .in_end_of_expr  (in_ch.end_of_expr),
    .out_ready       (out_ch.ready),
    .out_valid       (dp_out_valid),
    .out_value       (dp_out_value),
    .out_div_by_zero (dp_out_dz),
    .cmd             (cmd),
    .st              (st)
  );

  assign in_ch.ready        = ctl_in_ready;
  assign out_ch.valid       = dp_out_valid;
  assign out_ch.value       = dp_out_value;
  assign out_ch.div_by_zero = dp_out_dz;

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.take, cmd.apply_arith, cmd.div_start, cmd.div_commit, cmd.emit}))
    else $error("more than one datapath command in a cycle");

  // a closing byte stops intake for the next cycle
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && st.in_close) |=> !in_ch.ready)
    else $error("input accepted while a number is being closed");

  // the divider cannot finish right after it is started
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !st.div_done)
    else $error("divider finished without iterating");

  // an emitted result is presented on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted result not presented");

endmodule

// ===== sv/iee_ctrl.sv =====
`timescale 1ns / 1ps
// iee_ctrl: sequencing state machine for the evaluator
// depends on iee_pkg for the state enum and the command and status structs

module iee_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  iee_pkg::iee_stat_t st,
  output iee_pkg::iee_cmd_t  cmd
);
  import iee_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && st.in_close) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (st.op_is_div) begin
          state_nxt = S_DIV;
        end else if (st.last) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_nxt = st.last ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_APPLY: begin
        cmd.div_start   = st.op_is_div;
        cmd.apply_arith = !st.op_is_div;
      end
      S_DIV: begin
        cmd.div_commit = st.div_done;
      end
      S_EMIT: begin
        cmd.emit = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/iee_div.sv =====
`timescale 1ns / 1ps
// iee_div: unsigned restoring divider, one quotient bit per cycle
// depends on iee_pkg for the data width

module iee_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [iee_pkg::DATA_W-1:0]   num,
  input  logic [iee_pkg::DATA_W-1:0]   den,
  output logic                         done,
  output logic [iee_pkg::DATA_W-1:0]   quo
);
  import iee_pkg::*;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] den_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              qbit;

  // one trial subtraction
  always_comb begin
    shifted = {rem_r, quo_r[DATA_W-1]};
    diff    = shifted - {1'b0, den_r};
    qbit    = !diff[DATA_W];
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift registers, numerator bits shift out as quotient bits enter
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== sv/iee_dpath.sv =====
`timescale 1ns / 1ps
// iee_dpath: accumulator, pending term, running sum, operator and result registers
// depends on iee_pkg and instantiates the serial divider iee_div

module iee_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [iee_pkg::SYM_W-1:0]   in_symbol,
  input  logic                        in_end_of_expr,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [iee_pkg::DATA_W-1:0]  out_value,
  output logic                        out_div_by_zero,
  input  iee_pkg::iee_cmd_t            cmd,
  output iee_pkg::iee_stat_t           st
);
  import iee_pkg::*;

  logic [SYM_W-1:0]  symbol_r;
  logic              last_r;
  logic [DATA_W-1:0] accum_r, accum_nxt;
  logic [DATA_W-1:0] term_r, term_nxt;
  logic [DATA_W-1:0] sum_r, sum_nxt;
  op_t               op_r, op_nxt;
  logic              zdiv_r, zdiv_nxt;
  logic              div_neg_r;
  logic              div_zero_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_dz_r;

  logic [SYM_W-1:0]  digit_off;
  logic [DATA_W-1:0] accum_x10;
  logic [DATA_W-1:0] product;
  logic [DATA_W-1:0] num_mag;
  logic [DATA_W-1:0] den_mag;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] quo_signed;

  // digit fold: accum * 10 as two shifts and an add
  assign digit_off = in_symbol - CH_ZERO;
  assign accum_x10 = {accum_r[DATA_W-4:0], 3'b000} + {accum_r[DATA_W-2:0], 1'b0};

  // multiply for the pending term
  assign product = term_r * accum_r;

  // divider operands as magnitudes, sign restored on commit
  assign num_mag    = term_r[DATA_W-1] ? (-term_r) : term_r;
  assign den_mag    = accum_r[DATA_W-1] ? (-accum_r) : accum_r;
  assign quo_signed = div_zero_r ? '0 : (div_neg_r ? (-div_quo) : div_quo);

  iee_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_mag),
    .den   (den_mag),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next values of the expression state
  always_comb begin
    accum_nxt = accum_r;
    term_nxt  = term_r;
    sum_nxt   = sum_r;
    op_nxt    = op_r;
    zdiv_nxt  = zdiv_r;
    if (cmd.take && is_digit(in_symbol)) begin
      accum_nxt = accum_x10 + DATA_W'(digit_off[3:0]);
    end
    if (cmd.apply_arith) begin
      case (op_r)
        OP_ADD: begin
          sum_nxt  = sum_r + term_r;
          term_nxt = accum_r;
        end
        OP_SUB: begin
          sum_nxt  = sum_r + term_r;
          term_nxt = -accum_r;
        end
        OP_MUL: begin
          term_nxt = product;
        end
        default: begin
          term_nxt = term_r;
        end
      endcase
      accum_nxt = '0;
      op_nxt    = sym_op(symbol_r);
    end
    if (cmd.div_commit) begin
      term_nxt  = quo_signed;
      zdiv_nxt  = zdiv_r | div_zero_r;
      accum_nxt = '0;
      op_nxt    = sym_op(symbol_r);
    end
    if (cmd.emit) begin
      accum_nxt = '0;
      term_nxt  = '0;
      sum_nxt   = '0;
      op_nxt    = OP_ADD;
      zdiv_nxt  = 1'b0;
    end
  end

  // expression state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      term_r  <= '0;
      sum_r   <= '0;
      op_r    <= OP_ADD;
      zdiv_r  <= 1'b0;
    end else begin
      accum_r <= accum_nxt;
      term_r  <= term_nxt;
      sum_r   <= sum_nxt;
      op_r    <= op_nxt;
      zdiv_r  <= zdiv_nxt;
    end
  end

  // latched byte and divide sign bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      symbol_r <= in_symbol;
      last_r   <= in_end_of_expr;
    end
    if (cmd.div_start) begin
      div_neg_r  <= term_r[DATA_W-1] ^ accum_r[DATA_W-1];
      div_zero_r <= (accum_r == '0);
    end
  end

  // result register, held until the receiver takes the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= sum_r + term_r;
      out_dz_r    <= zdiv_r;
    end
  end

  // status toward the controller
  always_comb begin
    st.in_close  = (!is_digit(in_symbol) && !is_white(in_symbol)) || in_end_of_expr;
    st.last      = last_r;
    st.op_is_div = (op_r == OP_DIV);
    st.div_done  = div_done;
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_div_by_zero = out_dz_r;

endmodule
